// ===== design/abpp_pkg.sv =====
// Shared types, constants and the mask decoding function for the alpha blend
// and pixel packing pipeline. No dependencies.
`default_nettype none

package abpp_pkg;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CFG_BG_COLOR   = 8'd0,
    CFG_RED_MASK   = 8'd1,
    CFG_GREEN_MASK = 8'd2,
    CFG_BLUE_MASK  = 8'd3
  } cfg_reg_e;

  localparam logic [23:0] BG_COLOR_RST   = 24'h000000;
  localparam logic [31:0] RED_MASK_RST   = 32'h00FF0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000FF00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h000000FF;

  // Rounding bias and reciprocal of 255: floor(x * RECIP_255 / 2^39) == x / 255
  // for every 32-bit x.
  localparam logic [31:0] ROUND_BIAS  = 32'd127;
  localparam logic [31:0] RECIP_255   = 32'h80808081;
  localparam int unsigned RECIP_SHIFT = 39;
  localparam int unsigned QUOT_W      = 25;

  // Decoded form of one channel mask
  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  lsb;   // position of the lowest set bit
    logic [31:0] top;   // full-scale value of the lowest run of ones
  } field_t;

  typedef struct packed {
    logic [23:0] bg_color;
    field_t      red;
    field_t      green;
    field_t      blue;
  } cfg_t;

  // Load enables of the four register stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // Isolate the lowest set bit, then the run of ones above it by adding that
  // bit: the carry clears the run, and the XOR recovers it.
  function automatic field_t field_decode(logic [31:0] mask);
    logic [31:0] low;
    logic [31:0] run_bits;
    logic [4:0]  pos;
    field_t      f;
    low      = mask & (~mask + 32'd1);
    run_bits = mask & (mask ^ (mask + low));
    pos      = '0;
    for (int i = 0; i < 32; i++) begin
      if (low[i]) begin
        pos = pos | 5'(i);
      end
    end
    f.mask = mask;
    f.lsb  = pos;
    // Runs of 31 or 32 ones saturate to all ones
    if (run_bits == 32'hFFFFFFFF || run_bits == 32'h7FFFFFFF ||
        run_bits == 32'hFFFFFFFE) begin
      f.top = 32'hFFFFFFFF;
    end else begin
      f.top = run_bits >> pos;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== design/alpha_blend_pack_pixel_top.sv =====
// Alpha blend over a solid background and packing into channel mask fields.
// Four register stages (blend multiply, scale multiply, reciprocal multiply,
// pack), each with its own valid bit. Throughput one pixel per cycle while the
// output stream is ready; output back-pressure holds the full stages. Reset
// clears the stage valid bits and loads the configuration defaults (black
// background, 0x00RRGGBB masks).
// Depends on abpp_pkg, abpp_cfg, abpp_blend, abpp_scale.
`default_nettype none

module alpha_blend_pack_pixel_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // Pixel input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // red_in, green_in, blue_in, alpha_in
  // Packed pixel output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o   // packed_pixel
);

  abpp_pkg::cfg_t     cfg;
  abpp_pkg::pipe_en_t en;

  // Valid bit of each stage register, stage 1 in bit 0
  logic [3:0] vld_q, vld_d;
  // Stage k may take a new transfer when empty or when it drains downstream
  logic [4:0] stage_rdy;
  logic [3:0] stage_in_vld;

  logic [15:0] num_r, num_g, num_b;
  logic [abpp_pkg::QUOT_W-1:0] quot_r, quot_g, quot_b;
  logic [31:0] pix_q, pix_d;

  abpp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control: a stall only backs up as far as the first bubble
  // ---------------------------------------------------------------------------
  assign stage_in_vld = {vld_q[2:0], s_axis_tvalid_i};

  always_comb begin
    stage_rdy[4] = m_axis_tready_i;
    for (int k = 3; k >= 0; k--) begin
      stage_rdy[k] = !vld_q[k] || stage_rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    for (int k = 0; k < 4; k++) begin
      if (stage_rdy[k]) begin
        vld_d[k] = stage_in_vld[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Load a stage only when it advances and has something to take
  assign en.s1 = stage_rdy[0] && stage_in_vld[0];
  assign en.s2 = stage_rdy[1] && stage_in_vld[1];
  assign en.s3 = stage_rdy[2] && stage_in_vld[2];
  assign en.s4 = stage_rdy[3] && stage_in_vld[3];

  assign s_axis_tready_o = stage_rdy[0];

  // ---------------------------------------------------------------------------
  // Stage 1: blend numerators
  // ---------------------------------------------------------------------------
  abpp_blend u_blend_r (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (s_axis_tdata_i[7:0]),
    .alpha_i (s_axis_tdata_i[31:24]),
    .bg_i    (cfg.bg_color[23:16]),
    .num_o   (num_r)
  );

  abpp_blend u_blend_g (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (s_axis_tdata_i[15:8]),
    .alpha_i (s_axis_tdata_i[31:24]),
    .bg_i    (cfg.bg_color[15:8]),
    .num_o   (num_g)
  );

  abpp_blend u_blend_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (s_axis_tdata_i[23:16]),
    .alpha_i (s_axis_tdata_i[31:24]),
    .bg_i    (cfg.bg_color[7:0]),
    .num_o   (num_b)
  );

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: field scaling with rounding
  // ---------------------------------------------------------------------------
  abpp_scale u_scale_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num_r),
    .top_i  (cfg.red.top),
    .quot_o (quot_r)
  );

  abpp_scale u_scale_g (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num_g),
    .top_i  (cfg.green.top),
    .quot_o (quot_g)
  );

  abpp_scale u_scale_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num_b),
    .top_i  (cfg.blue.top),
    .quot_o (quot_b)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: shift into place, clip to the mask, merge. Bits of a mask above
  // its lowest run pass whatever the shifted value holds there; a zero mask
  // gives zero.
  // ---------------------------------------------------------------------------
  assign pix_d = ((32'(quot_r) << cfg.red.lsb)   & cfg.red.mask)
               | ((32'(quot_g) << cfg.green.lsb) & cfg.green.mask)
               | ((32'(quot_b) << cfg.blue.lsb)  & cfg.blue.mask);

  always_ff @(posedge clk_i) begin
    if (en.s4) begin
      pix_q <= pix_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[3];
  assign m_axis_tdata_o  = pix_q;

endmodule

`default_nettype wire

// ===== design/abpp_cfg.sv =====
// Configuration registers; decodes each channel mask as it is written.
// Depends on abpp_pkg.
`default_nettype none

module abpp_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [7:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  output abpp_pkg::cfg_t     cfg_o
);

  abpp_pkg::cfg_t cfg_q, cfg_d;
  abpp_pkg::field_t wr_field;

  assign cfg_ready_o = 1'b1;
  assign wr_field    = abpp_pkg::field_decode(cfg_data_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        abpp_pkg::CFG_BG_COLOR:   cfg_d.bg_color = cfg_data_i[23:0];
        abpp_pkg::CFG_RED_MASK:   cfg_d.red      = wr_field;
        abpp_pkg::CFG_GREEN_MASK: cfg_d.green    = wr_field;
        abpp_pkg::CFG_BLUE_MASK:  cfg_d.blue     = wr_field;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bg_color <= abpp_pkg::BG_COLOR_RST;
      cfg_q.red      <= abpp_pkg::field_decode(abpp_pkg::RED_MASK_RST);
      cfg_q.green    <= abpp_pkg::field_decode(abpp_pkg::GREEN_MASK_RST);
      cfg_q.blue     <= abpp_pkg::field_decode(abpp_pkg::BLUE_MASK_RST);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/abpp_blend.sv =====
// Stage 1: blend numerator c*a + bg*(255-a) for one colour channel.
// Depends on abpp_pkg.
`default_nettype none

module abpp_blend (
  input  wire logic                clk_i,
  input  wire abpp_pkg::pipe_en_t  en_i,
  input  wire logic [7:0]          chan_i,
  input  wire logic [7:0]          alpha_i,
  input  wire logic [7:0]          bg_i,
  output logic [15:0]              num_o
);

  logic [15:0] num_q, num_d;
  logic [7:0]  inv_alpha;

  assign inv_alpha = 8'd255 - alpha_i;
  // Max 255*255 fits 16 bits; an opaque pixel gives c*255, which divides back to c
  assign num_d = (16'(chan_i) * 16'(alpha_i)) + (16'(bg_i) * 16'(inv_alpha));

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

`default_nettype wire

// ===== design/abpp_scale.sv =====
// Stages 2 and 3: divide the blend numerator by 255, scale to the field's
// full-scale value, round and divide by 255 again. Depends on abpp_pkg.
`default_nettype none

module abpp_scale (
  input  wire logic                          clk_i,
  input  wire abpp_pkg::pipe_en_t            en_i,
  input  wire logic [15:0]                   num_i,
  input  wire logic [31:0]                   top_i,
  output logic [abpp_pkg::QUOT_W-1:0]        quot_o
);

  logic [7:0]  chan;
  logic [15:0] div_sum;
  logic [31:0] prod_q, prod_d;
  logic [31:0] biased;
  logic [63:0] recip_prod;
  logic [abpp_pkg::QUOT_W-1:0] quot_q, quot_d;

  // Exact x/255 for x below 65280; the 16-bit sum wraps above that
  assign div_sum = num_i + 16'd1 + {8'd0, num_i[15:8]};
  assign chan    = div_sum[15:8];
  assign prod_d  = 32'(chan * top_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= prod_d;
    end
  end

  // Bias wraps modulo 2^32
  assign biased     = prod_q + abpp_pkg::ROUND_BIAS;
  assign recip_prod = 64'(biased) * 64'(abpp_pkg::RECIP_255);
  assign quot_d     = recip_prod[abpp_pkg::RECIP_SHIFT +: abpp_pkg::QUOT_W];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== tb/sv/alpha_blend_pack_pixel_top_tb.sv =====
// Self-checking testbench for alpha_blend_pack_pixel_top: streams RGBA pixels,
// predicts each packed display pixel from its own blend and mask model.
// Depends on abpp_pkg and the alpha_blend_pack_pixel_top RTL.
`timescale 1ns / 1ps

module alpha_blend_pack_pixel_top_tb;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_PIXELS = 75;

  // tdata layout: red 7:0, green 15:8, blue 23:16, alpha 31:24
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic        clk;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_valid;
  logic        s_axis_tready_o;
  logic [31:0] s_data;
  logic        m_axis_tvalid_o;
  logic        m_ready;
  logic [31:0] m_axis_tdata_o;

  // Predictor copy of the configuration registers
  logic [23:0] bg_color;
  logic [31:0] red_fld;
  logic [31:0] green_fld;
  logic [31:0] blue_fld;

  pixel_t      pixel_q[$];
  logic [31:0] packed_due_q[$];

  bit          in_fire;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles;
  int unsigned mismatches;

  alpha_blend_pack_pixel_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Composite one channel over the background; opaque pixels pass through
  function automatic logic [7:0] mix_over_bg(logic [7:0] c, logic [7:0] bg, logic [7:0] a);
    logic [31:0] num;
    if (a == 8'hFF) begin
      return c;
    end
    num = 32'(c) * 32'(a) + 32'(bg) * (32'd255 - 32'(a));
    return 8'(num / 32'd255);
  endfunction

  // Scale an 8-bit channel into the lowest run of ones of the mask
  function automatic logic [31:0] fit_to_field(logic [7:0] v, logic [31:0] mask);
    int unsigned lsb;
    int unsigned run;
    logic [31:0] top;
    logic [31:0] biased;
    if (mask == '0) begin
      return '0;
    end
    lsb = 0;
    run = 0;
    while (lsb < 31 && !mask[lsb]) lsb++;
    while (lsb + run < 32 && mask[lsb + run]) run++;
    if (run == 0) begin
      return '0;
    end
    top    = (run >= 31) ? 32'hFFFF_FFFF : ((32'd1 << run) - 32'd1);
    biased = 32'(v) * top + 32'd127;  // wraps modulo 2^32
    return ((biased / 32'd255) << lsb) & mask;
  endfunction

  function automatic logic [31:0] predict_packed(pixel_t p);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = mix_over_bg(p.red,   bg_color[23:16], p.alpha);
    g = mix_over_bg(p.green, bg_color[15:8],  p.alpha);
    b = mix_over_bg(p.blue,  bg_color[7:0],   p.alpha);
    return fit_to_field(r, red_fld) | fit_to_field(g, green_fld) | fit_to_field(b, blue_fld);
  endfunction

  // Mix of mask shapes: empty, full, contiguous, gapped, arbitrary, byte lanes
  function automatic logic [31:0] pick_mask();
    int unsigned lsb;
    int unsigned w;
    logic [63:0] run_bits;
    lsb      = $urandom_range(31, 0);
    w        = $urandom_range(32 - lsb, 1);
    run_bits = ((64'd1 << w) - 64'd1) << lsb;
    case ($urandom_range(6, 0))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return run_bits[31:0];
      3: return run_bits[31:0] | ($urandom() & ~32'(((64'd1 << (lsb + w)) - 64'd1)));
      4: return $urandom();
      default: return 32'h0000_00FF << (8 * $urandom_range(3, 0));
    endcase
  endfunction

  // Take a transfer on either stream, track configuration, check results
  always @(posedge clk) begin
    in_fire = rst_ni && s_valid && s_axis_tready_o;
    if (rst_ni) begin
      if (in_fire) begin
        packed_due_q.push_back(predict_packed(pixel_q.pop_front()));
      end
      if (m_axis_tvalid_o && m_ready) begin
        if (packed_due_q.size() == 0) begin
          $display("%0t: unexpected packed pixel, expected none, got %08h",
                   $time, m_axis_tdata_o);
          mismatches++;
        end else if (m_axis_tdata_o !== packed_due_q[0]) begin
          $display("%0t: packed_pixel mismatch, expected %08h, got %08h",
                   $time, packed_due_q[0], m_axis_tdata_o);
          mismatches++;
          void'(packed_due_q.pop_front());
        end else begin
          void'(packed_due_q.pop_front());
        end
      end
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          abpp_pkg::CFG_BG_COLOR:   bg_color  = cfg_data[23:0];
          abpp_pkg::CFG_RED_MASK:   red_fld   = cfg_data;
          abpp_pkg::CFG_GREEN_MASK: green_fld = cfg_data;
          abpp_pkg::CFG_BLUE_MASK:  blue_fld  = cfg_data;
          default: ;  // unknown index: drop the write
        endcase
      end
      if (in_fire || (m_axis_tvalid_o && m_ready) || (cfg_valid && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Pixel sender and result receiver, both changing on the falling edge
  always @(negedge clk) begin
    if (!(s_valid && !in_fire)) begin
      if (rst_ni && pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        s_valid <= 1'b1;
        s_data  <= pixel_q[0];
      end else begin
        s_valid <= 1'b0;
      end
    end
    m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
  endtask

  // Write all four registers plus one write to an unmapped index
  task automatic load_setting(logic [31:0] bg, logic [31:0] rm, logic [31:0] gm,
                              logic [31:0] bm);
    write_reg(abpp_pkg::CFG_BG_COLOR, bg);
    write_reg(8'($urandom_range(255, abpp_pkg::CFG_BLUE_MASK + 1)), $urandom());
    write_reg(abpp_pkg::CFG_RED_MASK, rm);
    write_reg(abpp_pkg::CFG_GREEN_MASK, gm);
    write_reg(abpp_pkg::CFG_BLUE_MASK, bm);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every queued pixel has gone in and every result has come out
  task automatic settle();
    while (pixel_q.size() != 0 || packed_due_q.size() != 0) @(posedge clk);
  endtask

  // Corners of the pixel space: black, white, transparent, opaque, near-opaque
  task automatic push_corner_pixels();
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'hFFFF_FFFF);
    pixel_q.push_back(32'h00FF_FFFF);
    pixel_q.push_back(32'hFF00_0000);
    pixel_q.push_back(32'hFE80_00FF);
    pixel_q.push_back(32'h0103_0201);
    pixel_q.push_back(32'h7F20_4080);
    pixel_q.push_back(32'h80CC_55AA);
  endtask

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("alpha_blend_pack_pixel_top regression: fail");
    $finish;
  end

  initial begin
    pixel_t p;
    clk           = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_valid       = 1'b0;
    s_data        = '0;
    m_ready       = 1'b0;
    in_fire       = 1'b0;
    stall_cycles  = 0;
    mismatches    = 0;
    send_idle_pct = 38;
    recv_idle_pct = 45;
    bg_color      = abpp_pkg::BG_COLOR_RST;
    red_fld       = abpp_pkg::RED_MASK_RST;
    green_fld     = abpp_pkg::GREEN_MASK_RST;
    blue_fld      = abpp_pkg::BLUE_MASK_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset defaults: plain 0x00RRGGBB packing over black
    push_corner_pixels();
    settle();

    // White background (upper data bits dropped), empty red, gapped green,
    // full-width blue overlapping everything
    load_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'h0F0F_00F0, 32'hFFFF_FFFF);
    push_corner_pixels();
    settle();

    // 31-bit run, a single top bit, and a blue field overlapping red
    load_setting(32'h0012_3456, 32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FF00);
    push_corner_pixels();
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 38;
        recv_idle_pct = 45;
      end else if (ph < 7) begin
        send_idle_pct = 45;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      load_setting($urandom(), pick_mask(), pick_mask(), pick_mask());
      repeat (PHASE_PIXELS) begin
        p.red   = 8'($urandom_range(255, 0));
        p.green = 8'($urandom_range(255, 0));
        p.blue  = 8'($urandom_range(255, 0));
        case ($urandom_range(7, 0))
          0, 1: p.alpha = 8'hFF;
          2: p.alpha = 8'h00;
          default: p.alpha = 8'($urandom_range(255, 0));
        endcase
        pixel_q.push_back(p);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("alpha_blend_pack_pixel_top regression: pass");
    end else begin
      $display("alpha_blend_pack_pixel_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/abpp_pkg.sv
design/abpp_cfg.sv
design/abpp_blend.sv
design/abpp_scale.sv
design/alpha_blend_pack_pixel_top.sv
tb/sv/alpha_blend_pack_pixel_top_tb.sv
